// ===== rtl/bba_pkg.sv =====
// Shared types and codes of the buddy block allocator.
package bba_pkg;

    // Fixed field widths
    localparam int SIZE_W  = 21;
    localparam int USED_W  = 21;
    localparam int UNITS_W = 15;
    localparam int ADDR_W  = 32;
    localparam int KW      = 6;
    localparam int HDR_BYTES = 64;

    // Configuration register indexes
    localparam logic CFG_POOL_UNITS = 1'b0;
    localparam logic CFG_POOL_BASE  = 1'b1;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_INIT  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TOO_BIG = 2'd1,
        ST_NO_FREE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ROLE_NONE = 2'd0,
        ROLE_FREE = 2'd1,
        ROLE_USED = 2'd2
    } t_role;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE,
        S_ADEC, S_CHOOSE, S_POP, S_SPLIT,
        S_FDEC, S_FCHK, S_FBUD, S_FBCHK, S_FMRG, S_FPUSH,
        S_MK, S_MRD, S_MNXT, S_MBCK, S_MUL2, S_MJOIN, S_MPUSH,
        S_ULRD, S_ULCK,
        S_CARVE, S_DONE
    } t_state;

endpackage

// ===== rtl/bba_mem.sv =====
// Per-unit block table: one write port, one registered read port.
module bba_mem #(
    parameter int AW = 14,
    parameter int DW = 21
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bba_ctrl.sv =====
// Sequencer of the buddy allocator: free lists, splits, merges and pool carving.
module bba_ctrl
    import bba_pkg::*;
#(
    parameter int LOG_POOL_UNITS = 14,
    parameter int MIN_ORDER      = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_cmd,
    input  logic [SIZE_W-1:0]     i_size_bytes,
    input  logic                  i_worst_fit,
    input  logic [ADDR_W-1:0]     i_address,
    input  logic [UNITS_W-1:0]    i_pool_units,
    input  logic [ADDR_W-1:0]     i_pool_base,
    input  logic                  i_res_ready,
    output logic                  o_res_valid,
    output logic [1:0]            o_status,
    output logic [ADDR_W-1:0]     o_result_address,
    output logic [USED_W-1:0]     o_bytes_in_use,
    output logic                  o_mem_we,
    output logic [LOG_POOL_UNITS-1:0] o_mem_waddr,
    output logic [2+$clog2(LOG_POOL_UNITS+1)+LOG_POOL_UNITS:0] o_mem_wdata,
    output logic [LOG_POOL_UNITS-1:0] o_mem_raddr,
    input  logic [2+$clog2(LOG_POOL_UNITS+1)+LOG_POOL_UNITS:0] i_mem_rdata
);

    localparam int LOG   = LOG_POOL_UNITS;
    localparam int UNITS = 1 << LOG;
    localparam int NORD  = LOG + 1;
    localparam int LINKW = LOG + 1;
    localparam int OW    = $clog2(NORD);
    localparam int DW    = 2 + OW + LINKW;
    localparam int UNIT_BYTES = 1 << MIN_ORDER;
    localparam logic [LINKW-1:0] NIL = LINKW'(UNITS);

    // highest set bit, 0 for zero
    function automatic logic [4:0] f_msb(input logic [31:0] v);
        logic [4:0] pos;
        pos = '0;
        for (int j = 0; j < 32; j++) begin
            if (v[j]) pos = 5'(j);
        end
        return pos;
    endfunction

    // lowest set bit, 0 for zero
    function automatic logic [4:0] f_lsb(input logic [31:0] v);
        logic [4:0] pos;
        pos = '0;
        for (int j = 31; j >= 0; j--) begin
            if (v[j]) pos = 5'(j);
        end
        return pos;
    endfunction

    function automatic logic [DW-1:0] f_pack(input t_role role, input logic [OW-1:0] ord,
                                              input logic [LINKW-1:0] link);
        return {role, ord, link};
    endfunction

    // state
    t_state            r_state, n_state, r_ret, n_ret;
    logic [LINKW-1:0]  r_head [NORD];
    logic [LINKW-1:0]  n_head [NORD];
    logic [NORD-1:0]   r_mask, n_mask;
    logic [OW-1:0]     r_top, n_top;
    logic [USED_W-1:0] r_used, n_used;
    logic [LOG-1:0]    r_clr, n_clr;
    logic              r_initing, n_initing;
    logic [SIZE_W-1:0] r_size, n_size;
    logic              r_worst, n_worst;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic              r_retry, n_retry;
    t_status           r_status, n_status;
    logic [ADDR_W-1:0] r_res, n_res;
    logic [KW-1:0]     r_k, n_k;
    logic [OW-1:0]     r_o, n_o;
    logic [LOG-1:0]    r_idx, n_idx, r_p, n_p, r_tgt, n_tgt;
    logic [LINKW-1:0]  r_cur, n_cur, r_prev, n_prev, r_mcur, n_mcur, r_mnxt, n_mnxt;
    logic [OW-1:0]     r_uk, n_uk, r_mk, n_mk;
    logic [LINKW-1:0]  r_n, n_n, r_off, n_off;

    // helpers
    t_role             rd_role;
    logic [OW-1:0]     rd_ord;
    logic [LINKW-1:0]  rd_link;
    logic [SIZE_W:0]   need;
    logic [KW-1:0]     ob, k_calc;
    logic [NORD-1:0]   fit;
    logic [OW-1:0]     pick;
    logic [31:0]       pu32;
    logic [LINKW-1:0]  n_calc;
    logic [OW-1:0]     top_calc;
    logic [LINKW-1:0]  diff;
    logic [OW-1:0]     co_a, co_b, carve_o;
    logic [ADDR_W-1:0] foff;
    logic              foff_ok;
    logic [LOG+MIN_ORDER-1:0] byte_off;
    logic              push_en, ul_go;
    logic [OW-1:0]     push_ord, ul_ord;
    logic [LOG-1:0]    push_idx, ul_tgt, pb, lo_idx, hi_idx;
    t_state            ul_ret;

    assign rd_role = t_role'(i_mem_rdata[DW-1 -: 2]);
    assign rd_ord  = i_mem_rdata[LINKW +: OW];
    assign rd_link = i_mem_rdata[LINKW-1:0];

    // request size to order
    always_comb begin
        need = (SIZE_W+1)'(r_size) + (SIZE_W+1)'(HDR_BYTES);
        if (need > (SIZE_W+1)'(UNIT_BYTES)) begin
            ob = KW'(f_msb(32'(need - 1'b1))) + KW'(1);
        end else begin
            ob = KW'(MIN_ORDER);
        end
        k_calc = ob - KW'(MIN_ORDER);
    end

    // order choice over the non-empty lists
    always_comb begin
        for (int j = 0; j < NORD; j++) begin
            fit[j] = r_mask[j] && (j <= int'(r_top)) && (j >= int'(r_k));
        end
        pick = r_worst ? OW'(f_msb(32'(fit))) : OW'(f_lsb(32'(fit)));
    end

    // pool length and carve step
    always_comb begin
        pu32     = 32'(i_pool_units);
        n_calc   = (pu32 > 32'(UNITS)) ? LINKW'(UNITS) : LINKW'(pu32);
        top_calc = (n_calc == '0) ? '0 : OW'(f_msb(32'(n_calc)));
        diff     = r_n - r_off;
        co_a     = OW'(f_msb(32'(diff)));
        co_b     = (r_off == '0) ? r_top : OW'(f_lsb(32'(r_off)));
        carve_o  = (co_a < co_b) ? co_a : co_b;
    end

    // free address decode
    always_comb begin
        foff    = r_addr - i_pool_base - ADDR_W'(HDR_BYTES);
        foff_ok = (foff[MIN_ORDER-1:0] == '0) && ((foff >> (MIN_ORDER + LOG)) == '0);
        byte_off = {r_idx, {MIN_ORDER{1'b0}}};
        pb      = r_idx ^ (LOG'(1) << r_o);
        lo_idx  = (LINKW'(r_p) < r_mcur) ? r_p : r_mcur[LOG-1:0];
        hi_idx  = (LINKW'(r_p) < r_mcur) ? r_mcur[LOG-1:0] : r_p;
    end

    // next state and outputs
    always_comb begin
        n_state = r_state;   n_ret = r_ret;
        n_head  = r_head;    n_mask = r_mask;   n_top = r_top;   n_used = r_used;
        n_clr   = r_clr;     n_initing = r_initing;
        n_size  = r_size;    n_worst = r_worst; n_addr = r_addr; n_retry = r_retry;
        n_status = r_status; n_res = r_res;     n_k = r_k;       n_o = r_o;
        n_idx   = r_idx;     n_p = r_p;         n_tgt = r_tgt;
        n_cur   = r_cur;     n_prev = r_prev;   n_mcur = r_mcur; n_mnxt = r_mnxt;
        n_uk    = r_uk;      n_mk = r_mk;       n_n = r_n;       n_off = r_off;
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = '0;
        o_mem_raddr = '0;
        o_in_stall  = 1'b1;
        o_res_valid = 1'b0;
        push_en  = 1'b0; push_ord = '0; push_idx = '0;
        ul_go    = 1'b0; ul_ord = '0;   ul_tgt = '0;  ul_ret = S_DONE;

        case (r_state)
            // zero the unit table after reset and on init
            S_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr;
                n_clr       = r_clr + 1'b1;
                if (&r_clr) begin
                    n_off   = '0;
                    n_state = r_initing ? S_CARVE : S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_size   = i_size_bytes;
                    n_worst  = i_worst_fit;
                    n_addr   = i_address;
                    n_status = ST_OK;
                    n_res    = '0;
                    n_retry  = 1'b0;
                    case (t_cmd'(i_cmd))
                        CMD_ALLOC: n_state = S_ADEC;
                        CMD_FREE:  n_state = (i_address == '0) ? S_DONE : S_FDEC;
                        CMD_INIT: begin
                            for (int j = 0; j < NORD; j++) n_head[j] = NIL;
                            n_mask    = '0;
                            n_used    = '0;
                            n_n       = n_calc;
                            n_top     = top_calc;
                            n_initing = 1'b1;
                            n_clr     = '0;
                            n_state   = S_CLEAR;
                        end
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            // allocation
            S_ADEC: begin
                n_k = k_calc;
                if (k_calc > KW'(r_top)) begin
                    n_status = ST_TOO_BIG;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_CHOOSE;
                end
            end
            S_CHOOSE: begin
                if (fit != '0) begin
                    n_o         = pick;
                    n_idx       = r_head[pick][LOG-1:0];
                    o_mem_raddr = r_head[pick][LOG-1:0];
                    n_state     = S_POP;
                end else if (!r_retry) begin
                    n_retry = 1'b1;
                    n_mk    = '0;
                    n_state = S_MK;
                end else begin
                    n_status = ST_NO_FREE;
                    n_state  = S_DONE;
                end
            end
            S_POP: begin
                n_head[r_o] = rd_link;
                if (rd_link == NIL) n_mask[r_o] = 1'b0;
                n_state = S_SPLIT;
            end
            S_SPLIT: begin
                if (KW'(r_o) > r_k) begin
                    n_o      = r_o - 1'b1;
                    push_en  = 1'b1;
                    push_ord = r_o - 1'b1;
                    push_idx = r_idx + (LOG'(1) << (r_o - 1'b1));
                end else begin
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_idx;
                    o_mem_wdata = f_pack(ROLE_USED, OW'(r_k), '0);
                    n_used      = r_used + (USED_W'(1) << (MIN_ORDER + int'(r_k)));
                    n_res       = i_pool_base + ADDR_W'(byte_off) + ADDR_W'(HDR_BYTES);
                    n_state     = S_DONE;
                end
            end
            // free
            S_FDEC: begin
                if (foff_ok) begin
                    n_idx       = LOG'(foff >> MIN_ORDER);
                    o_mem_raddr = LOG'(foff >> MIN_ORDER);
                    n_state     = S_FCHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FCHK: begin
                if (rd_role == ROLE_USED) begin
                    n_o         = rd_ord;
                    n_used      = r_used - (USED_W'(1) << (MIN_ORDER + int'(rd_ord)));
                    o_mem_we    = 1'b1;
                    o_mem_waddr = r_idx;
                    o_mem_wdata = f_pack(ROLE_NONE, '0, '0);
                    n_state     = S_FBUD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_FBUD: begin
                if (r_o < r_top) begin
                    n_p         = pb;
                    o_mem_raddr = pb;
                    n_state     = S_FBCHK;
                end else begin
                    n_state = S_FPUSH;
                end
            end
            S_FBCHK: begin
                if (rd_role == ROLE_FREE && rd_ord == r_o) begin
                    ul_go  = 1'b1;
                    ul_ord = r_o;
                    ul_tgt = r_p;
                    ul_ret = S_FMRG;
                end else begin
                    n_state = S_FPUSH;
                end
            end
            S_FMRG: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_p;
                o_mem_wdata = f_pack(ROLE_NONE, '0, '0);
                if (r_p < r_idx) n_idx = r_p;
                n_o     = r_o + 1'b1;
                n_state = S_FBUD;
            end
            S_FPUSH: begin
                push_en  = 1'b1;
                push_ord = r_o;
                push_idx = r_idx;
                n_state  = S_DONE;
            end
            // merge pass over orders below the top
            S_MK: begin
                if (r_mk < r_top) begin
                    n_mcur  = r_head[r_mk];
                    n_state = S_MRD;
                end else begin
                    n_state = S_CHOOSE;
                end
            end
            S_MRD: begin
                if (r_mcur == NIL) begin
                    n_mk    = r_mk + 1'b1;
                    n_state = S_MK;
                end else begin
                    o_mem_raddr = r_mcur[LOG-1:0];
                    n_state     = S_MNXT;
                end
            end
            S_MNXT: begin
                n_mnxt      = rd_link;
                n_p         = r_mcur[LOG-1:0] ^ (LOG'(1) << r_mk);
                o_mem_raddr = r_mcur[LOG-1:0] ^ (LOG'(1) << r_mk);
                n_state     = S_MBCK;
            end
            S_MBCK: begin
                if (rd_role == ROLE_FREE && rd_ord == r_mk) begin
                    ul_go  = 1'b1;
                    ul_ord = r_mk;
                    ul_tgt = r_mcur[LOG-1:0];
                    ul_ret = S_MUL2;
                end else begin
                    n_mcur  = r_mnxt;
                    n_state = S_MRD;
                end
            end
            S_MUL2: begin
                ul_go  = 1'b1;
                ul_ord = r_mk;
                ul_tgt = r_p;
                ul_ret = S_MJOIN;
            end
            S_MJOIN: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = hi_idx;
                o_mem_wdata = f_pack(ROLE_NONE, '0, '0);
                n_state     = S_MPUSH;
            end
            S_MPUSH: begin
                push_en  = 1'b1;
                push_ord = r_mk + 1'b1;
                push_idx = lo_idx;
                n_mcur   = r_head[r_mk];
                n_state  = S_MRD;
            end
            // unlink one block from list r_uk
            S_ULRD: begin
                if (r_cur == NIL) begin
                    n_state = r_ret;
                end else begin
                    o_mem_raddr = r_cur[LOG-1:0];
                    n_state     = S_ULCK;
                end
            end
            S_ULCK: begin
                if (r_cur == LINKW'(r_tgt)) begin
                    if (r_prev == NIL) begin
                        n_head[r_uk] = rd_link;
                        if (rd_link == NIL) n_mask[r_uk] = 1'b0;
                    end else begin
                        o_mem_we    = 1'b1;
                        o_mem_waddr = r_prev[LOG-1:0];
                        o_mem_wdata = f_pack(ROLE_FREE, r_uk, rd_link);
                    end
                    n_state = r_ret;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = rd_link;
                    n_state = S_ULRD;
                end
            end
            // carve the pool into aligned blocks
            S_CARVE: begin
                if (r_off >= r_n) begin
                    n_initing = 1'b0;
                    n_state   = S_DONE;
                end else begin
                    push_en  = 1'b1;
                    push_ord = carve_o;
                    push_idx = r_off[LOG-1:0];
                    n_off    = r_off + (LINKW'(1) << carve_o);
                end
            end
            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // push a free block on its list
        if (push_en) begin
            o_mem_we         = 1'b1;
            o_mem_waddr      = push_idx;
            o_mem_wdata      = f_pack(ROLE_FREE, push_ord, r_head[push_ord]);
            n_head[push_ord] = LINKW'(push_idx);
            n_mask[push_ord] = 1'b1;
        end

        // start a list walk to unlink a block
        if (ul_go) begin
            n_uk    = ul_ord;
            n_tgt   = ul_tgt;
            n_ret   = ul_ret;
            n_cur   = r_head[ul_ord];
            n_prev  = NIL;
            n_state = S_ULRD;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            for (int j = 0; j < NORD; j++) r_head[j] <= NIL;
            r_mask    <= '0;
            r_top     <= '0;
            r_used    <= '0;
            r_clr     <= '0;
            r_initing <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_mask    <= n_mask;
            r_top     <= n_top;
            r_used    <= n_used;
            r_clr     <= n_clr;
            r_initing <= n_initing;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_ret <= n_ret;   r_size <= n_size;   r_worst <= n_worst; r_addr <= n_addr;
        r_retry <= n_retry; r_status <= n_status; r_res <= n_res; r_k <= n_k;
        r_o <= n_o;       r_idx <= n_idx;     r_p <= n_p;         r_tgt <= n_tgt;
        r_cur <= n_cur;   r_prev <= n_prev;   r_mcur <= n_mcur;   r_mnxt <= n_mnxt;
        r_uk <= n_uk;     r_mk <= n_mk;       r_n <= n_n;         r_off <= n_off;
    end

    assign o_status         = r_status;
    assign o_result_address = r_res;
    assign o_bytes_in_use   = r_used;

endmodule

// ===== rtl/buddy_block_allocator_top.sv =====
// Top level of the buddy block allocator: configuration, output register, table and sequencer.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------------------
//  in      | in        | i_in_valid / o_in_stall   | i_cmd, i_size_bytes, i_worst_fit, i_address
//  out     | out       | o_out_valid / i_out_stall | o_status, o_result_address, o_bytes_in_use
//  cfg     | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One item at a time through a sequencer around a one-read, one-write unit table.
// Allocate: decode, order choice, pop, then a split step per order halved; a merge pass visits
// each free-list entry, and every unlink walks its list entry by entry.
// Init: the table is cleared, then the pool is carved one block at a time.
// After reset the table is cleared with the input stalled.
// The output register lets the next item in while a result waits on i_out_stall.
module buddy_block_allocator_top
    import bba_pkg::*;
#(
    parameter int LOG_POOL_UNITS = 14,
    parameter int MIN_ORDER      = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [1:0]          i_cmd,
    input  logic [SIZE_W-1:0]   i_size_bytes,
    input  logic                i_worst_fit,
    input  logic [ADDR_W-1:0]   i_address,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [1:0]          o_status,
    output logic [ADDR_W-1:0]   o_result_address,
    output logic [USED_W-1:0]   o_bytes_in_use,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [ADDR_W-1:0]   i_cfg_data
);

    localparam int DW = 2 + $clog2(LOG_POOL_UNITS + 1) + LOG_POOL_UNITS + 1;

    logic [UNITS_W-1:0]        r_pool_units;
    logic [ADDR_W-1:0]         r_pool_base;
    logic                      r_out_valid;
    logic [1:0]                r_status;
    logic [ADDR_W-1:0]         r_result_address;
    logic [USED_W-1:0]         r_bytes_in_use;
    logic                      res_ready, res_valid;
    logic [1:0]                res_status;
    logic [ADDR_W-1:0]         res_address;
    logic [USED_W-1:0]         res_used;
    logic                      mem_we;
    logic [LOG_POOL_UNITS-1:0] mem_waddr, mem_raddr;
    logic [DW-1:0]             mem_wdata, mem_rdata;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_units <= UNITS_W'(16384);
            r_pool_base  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POOL_UNITS: r_pool_units <= i_cfg_data[UNITS_W-1:0];
                CFG_POOL_BASE:  r_pool_base  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // output register
    assign res_ready = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_status         <= res_status;
            r_result_address <= res_address;
            r_bytes_in_use   <= res_used;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_result_address = r_result_address;
    assign o_bytes_in_use   = r_bytes_in_use;

    bba_mem #(
        .AW (LOG_POOL_UNITS),
        .DW (DW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    bba_ctrl #(
        .LOG_POOL_UNITS (LOG_POOL_UNITS),
        .MIN_ORDER      (MIN_ORDER)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_size_bytes     (i_size_bytes),
        .i_worst_fit      (i_worst_fit),
        .i_address        (i_address),
        .i_pool_units     (r_pool_units),
        .i_pool_base      (r_pool_base),
        .i_res_ready      (res_ready),
        .o_res_valid      (res_valid),
        .o_status         (res_status),
        .o_result_address (res_address),
        .o_bytes_in_use   (res_used),
        .o_mem_we         (mem_we),
        .o_mem_waddr      (mem_waddr),
        .o_mem_wdata      (mem_wdata),
        .o_mem_raddr      (mem_raddr),
        .i_mem_rdata      (mem_rdata)
    );

endmodule

// ===== sim/tb_buddy_block_allocator_top.sv =====
// Self-checking testbench of the buddy block allocator top level.
module tb_buddy_block_allocator_top
    import bba_pkg::*;
();

    localparam int NUNITS    = 16384;
    localparam int NORD      = 15;
    localparam int NIL       = 16384;
    localparam int UNIT_B    = 64;
    localparam int CYC_LIMIT = 6000000;
    localparam logic [1:0] CMD_NONE = 2'd3;

    typedef struct {
        t_status     st;
        logic [31:0] addr;
        logic [20:0] used;
    } t_grant;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = CMD_ALLOC;
    logic [20:0] size_b = '0;
    logic        worst = 1'b0;
    logic [31:0] addr = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [31:0] res_addr;
    logic [20:0] in_use;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = CFG_POOL_UNITS;
    logic [31:0] cfg_data = '0;

    // Shadow allocator state
    int unsigned  sh_head [NORD];
    int unsigned  sh_link [NUNITS];
    int unsigned  sh_ord  [NUNITS];
    t_role        sh_role [NUNITS];
    int unsigned  sh_mask, sh_top, sh_used;
    int unsigned  sh_units, sh_base;

    t_grant       grant_q[$];
    int unsigned  live_q[$];
    int           n_bad = 0;
    int           cyc = 0;
    bit           idle_en = 1'b1;
    int           stall_left = 0;

    buddy_block_allocator_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_cmd(cmd), .i_size_bytes(size_b), .i_worst_fit(worst), .i_address(addr),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_status(status), .o_result_address(res_addr), .o_bytes_in_use(in_use),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_idx), .i_cfg_data(cfg_data)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Cycle count and run limit
    always @(posedge clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("tb_buddy_block_allocator_top: FAIL");
            $finish;
        end
    end

    // Receiver stalls in random bursts
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 12);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Result check against the oldest expectation
    always @(posedge clk) begin
        t_grant g;
        if (out_valid && !out_stall) begin
            if (grant_q.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("unexpected result: status %0d addr %h", status, res_addr);
            end else begin
                g = grant_q.pop_front();
                if (status !== g.st || res_addr !== g.addr || in_use !== g.used) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("mismatch: exp st %0d addr %h used %0d, got st %0d addr %h used %0d",
                                 g.st, g.addr, g.used, status, res_addr, in_use);
                end
            end
        end
    end

    function automatic int unsigned log2_floor(int unsigned v);
        int unsigned r = 0;
        while (v > 1) begin
            v = v >> 1;
            r++;
        end
        return r;
    endfunction

    function automatic void shadow_push(int unsigned k, int unsigned idx);
        sh_link[idx] = sh_head[k];
        sh_head[k]   = idx;
        sh_ord[idx]  = k;
        sh_role[idx] = ROLE_FREE;
        sh_mask |= 1 << k;
    endfunction

    function automatic int unsigned list_pop(int unsigned k);
        int unsigned idx = sh_head[k];
        sh_head[k] = sh_link[idx];
        if (sh_head[k] == NIL) sh_mask &= ~(1 << k);
        return idx;
    endfunction

    function automatic void list_unlink(int unsigned k, int unsigned idx);
        int unsigned prev = NIL;
        int unsigned cur = sh_head[k];
        while (cur != NIL) begin
            if (cur == idx) begin
                if (prev == NIL) sh_head[k] = sh_link[cur];
                else sh_link[prev] = sh_link[cur];
                if (sh_head[k] == NIL) sh_mask &= ~(1 << k);
                return;
            end
            prev = cur;
            cur  = sh_link[cur];
        end
    endfunction

    // Buddy counts only if it heads a free block of the same order
    function automatic bit buddy_free(int unsigned idx, int unsigned k, output int unsigned p);
        p = idx ^ (1 << k);
        if (p >= NUNITS) return 1'b0;
        return sh_role[p] == ROLE_FREE && sh_ord[p] == k;
    endfunction

    function automatic void merge_lists();
        int unsigned cur, nxt, p, lo, hi;
        for (int unsigned k = 0; k < sh_top; k++) begin
            cur = sh_head[k];
            while (cur != NIL) begin
                nxt = sh_link[cur];
                if (buddy_free(cur, k, p)) begin
                    lo = cur < p ? cur : p;
                    hi = cur < p ? p : cur;
                    list_unlink(k, cur);
                    list_unlink(k, p);
                    sh_role[hi] = ROLE_NONE;
                    shadow_push(k + 1, lo);
                    cur = sh_head[k];
                end else begin
                    cur = nxt;
                end
            end
        end
    endfunction

    function automatic bit pick_order(int unsigned k, bit wf, output int unsigned o);
        int unsigned m = sh_mask & ((1 << (sh_top + 1)) - 1) & (32'hFFFF_FFFF << k);
        o = 0;
        if (m == 0) return 1'b0;
        if (wf) o = log2_floor(m);
        else while (((m >> o) & 1) == 0) o++;
        return 1'b1;
    endfunction

    function automatic void carve_pool();
        int unsigned n = sh_units;
        int unsigned off = 0;
        int unsigned o;
        foreach (sh_role[i]) sh_role[i] = ROLE_NONE;
        foreach (sh_head[i]) sh_head[i] = NIL;
        sh_mask = 0;
        sh_used = 0;
        if (n > NUNITS) n = NUNITS;
        sh_top = n ? log2_floor(n) : 0;
        while (off < n) begin
            o = sh_top;
            while (o > 0 && (((1 << o) > n - off) || (off & ((1 << o) - 1)))) o--;
            shadow_push(o, off);
            off += 1 << o;
        end
    endfunction

    // Expected result of one accepted item; also tracks live grants
    function automatic t_grant alloc_predict(logic [1:0] c, logic [20:0] sz, bit wf,
                                             logic [31:0] a);
        t_grant g;
        longint unsigned need;
        int unsigned ob, k, o, idx, p;
        logic [31:0] off;
        bit found;
        g.st   = ST_OK;
        g.addr = '0;
        if (c == CMD_ALLOC) begin
            need = longint'(sz) + HDR_BYTES;
            ob = 6;
            if (need > UNIT_B) ob = log2_floor(int'(need - 1)) + 1;
            k = ob - 6;
            if (k > sh_top) begin
                g.st = ST_TOO_BIG;
            end else begin
                found = pick_order(k, wf, o);
                if (!found) begin
                    merge_lists();
                    found = pick_order(k, wf, o);
                end
                if (!found) begin
                    g.st = ST_NO_FREE;
                end else begin
                    idx = list_pop(o);
                    while (o > k) begin
                        o--;
                        shadow_push(o, idx + (1 << o));
                    end
                    sh_ord[idx]  = k;
                    sh_role[idx] = ROLE_USED;
                    sh_used += UNIT_B << k;
                    g.addr = sh_base + idx * UNIT_B + HDR_BYTES;
                    live_q.push_back(g.addr);
                end
            end
        end else if (c == CMD_FREE && a != 0) begin
            off = a - sh_base - HDR_BYTES;
            idx = off >> 6;
            if (off[5:0] == 0 && idx < NUNITS && sh_role[idx] == ROLE_USED) begin
                foreach (live_q[i]) if (live_q[i] == a) begin
                    live_q.delete(i);
                    break;
                end
                k = sh_ord[idx];
                sh_used -= UNIT_B << k;
                sh_role[idx] = ROLE_NONE;
                while (k < sh_top && buddy_free(idx, k, p)) begin
                    list_unlink(k, p);
                    sh_role[p] = ROLE_NONE;
                    if (p < idx) idx = p;
                    k++;
                end
                shadow_push(k, idx);
            end
        end else if (c == CMD_INIT) begin
            carve_pool();
            live_q.delete();
        end
        g.used = sh_used[20:0];
        return g;
    endfunction

    // Send one item, with an optional random gap in front
    task automatic send_item(logic [1:0] c, logic [20:0] sz, bit wf, logic [31:0] a);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        size_b   <= sz;
        worst    <= wf;
        addr     <= a;
        do @(posedge clk); while (in_stall);
        grant_q.push_back(alloc_predict(c, sz, wf, a));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic i, logic [31:0] d);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= i;
        cfg_data <= d;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (i == CFG_POOL_UNITS) sh_units = d[14:0];
        else sh_base = d;
    endtask

    task automatic free_live();
        send_item(CMD_FREE, 21'($urandom), 1'($urandom), live_q.size() ? live_q[0] : 32'd0);
    endtask

    // Empty pool before any init
    task automatic test_before_init();
        send_item(CMD_ALLOC, 21'd0, 1'b0, 32'd0);
        send_item(CMD_ALLOC, 21'd1, 1'b1, 32'd0);
        send_item(CMD_NONE, 21'h1F_FFFF, 1'b1, 32'hFFFF_FFFF);
        send_item(CMD_FREE, 21'd0, 1'b0, 32'd0);
        send_item(CMD_FREE, 21'd0, 1'b0, 32'd64);
    endtask

    // Whole-pool grant, oversize, double and malformed frees
    task automatic test_full_pool();
        send_item(CMD_INIT, 21'd0, 1'b0, 32'd0);
        send_item(CMD_ALLOC, 21'd1048512, 1'b0, 32'd0);
        send_item(CMD_ALLOC, 21'd0, 1'b0, 32'd0);
        send_item(CMD_FREE, 21'd0, 1'b0, 32'd64);
        send_item(CMD_FREE, 21'd0, 1'b0, 32'd64);
        send_item(CMD_ALLOC, 21'd0, 1'b1, 32'd0);
        send_item(CMD_ALLOC, 21'd1048576, 1'b0, 32'd0);
        send_item(CMD_ALLOC, 21'd1048513, 1'b0, 32'd0);
        send_item(CMD_FREE, 21'd0, 1'b0, 32'd65);
        send_item(CMD_FREE, 21'd0, 1'b0, 32'hFFFF_FFC0);
        send_item(CMD_ALLOC, 21'd100, 1'b0, 32'd0);
        free_live();
        free_live();
    endtask

    // Empty, saturated and single-unit pools, base wrapping round
    task automatic test_pool_limits();
        write_reg(CFG_POOL_UNITS, 32'd0);
        send_item(CMD_INIT, 21'd0, 1'b0, 32'd0);
        send_item(CMD_ALLOC, 21'd0, 1'b0, 32'd0);
        write_reg(CFG_POOL_UNITS, 32'h7FFF);
        write_reg(CFG_POOL_BASE, 32'hFFFF_FFC0);
        send_item(CMD_INIT, 21'd0, 1'b0, 32'd0);
        send_item(CMD_ALLOC, 21'd0, 1'b0, 32'd0);
        send_item(CMD_ALLOC, 21'd0, 1'b0, 32'd0);
        send_item(CMD_FREE, 21'd0, 1'b0, 32'd64);
        write_reg(CFG_POOL_UNITS, 32'd1);
        write_reg(CFG_POOL_BASE, 32'hFFFF_FFFF);
        send_item(CMD_INIT, 21'd0, 1'b0, 32'd0);
        send_item(CMD_ALLOC, 21'd0, 1'b1, 32'd0);
        send_item(CMD_ALLOC, 21'd0, 1'b0, 32'd0);
        free_live();
    endtask

    // Random mix over a small pool: mostly grants and real frees
    task automatic test_random(int n_items);
        int r;
        logic [20:0] sz;
        logic [31:0] a;
        write_reg(CFG_POOL_UNITS, $urandom_range(0, 3) == 0 ? $urandom_range(1, 8)
                                                             : $urandom_range(9, 300));
        write_reg(CFG_POOL_BASE, $urandom);
        send_item(CMD_INIT, 21'($urandom), 1'($urandom), $urandom);
        repeat (n_items) begin
            r  = $urandom_range(0, 99);
            sz = $urandom_range(0, 9) == 0 ? 21'($urandom) : 21'($urandom_range(0, 1500));
            a  = $urandom;
            if (r < 48) begin
                send_item(CMD_ALLOC, sz, 1'($urandom), a);
            end else if (r < 90) begin
                if (live_q.size() && $urandom_range(0, 7) != 0)
                    a = live_q[$urandom_range(0, live_q.size() - 1)];
                else if ($urandom_range(0, 1)) a = sh_base + 64 * $urandom_range(0, 400)
                                                   + $urandom_range(0, 1) * 64;
                send_item(CMD_FREE, sz, 1'($urandom), a);
            end else if (r < 98) begin
                send_item(CMD_NONE, sz, 1'($urandom), a);
            end else begin
                send_item(CMD_INIT, sz, 1'($urandom), a);
            end
        end
    endtask

    initial begin
        foreach (sh_head[i]) sh_head[i] = NIL;
        foreach (sh_role[i]) sh_role[i] = ROLE_NONE;
        sh_mask  = 0;
        sh_top   = 0;
        sh_used  = 0;
        sh_units = 16384;
        sh_base  = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_before_init();
        test_full_pool();
        test_pool_limits();
        repeat (4) test_random(300);
        idle_en = 1'b0;
        test_random(300);
        drain();
        if (n_bad == 0 && grant_q.size() == 0) begin
            $display("tb_buddy_block_allocator_top: PASS");
        end else begin
            $display("tb_buddy_block_allocator_top: FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bba_pkg.sv
rtl/bba_mem.sv
rtl/bba_ctrl.sv
rtl/buddy_block_allocator_top.sv
sim/tb_buddy_block_allocator_top.sv
